// ----- hdl/mhb_pkg.sv -----
// shared types and codes for the multi-ring history buffer
package mhb_pkg;

  // register write data width (widest register)
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;

  // action codes on the input beat
  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_HIST  = 3'd1,
    ACT_COUNT = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_BUF = 2'd1,
    STAT_BAD_OFF = 2'd2
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE    = 2'd0,
    CFG_LENGTH    = 2'd1,
    CFG_COUNT_SEL = 2'd2
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_META,
    S_ACCESS,
    S_RESULT
  } state_e;

  // input beat
  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         buffer_sel;
    logic signed [31:0] sample_in;
    logic [9:0]         steps_back;
    logic [7:0]         elem_offset;
    logic               last_elem;
  } in_t;

  // result beat
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
  } out_t;

endpackage

// ----- hdl/mhb_ram.sv -----
// generic single-port synchronous ram with registered read
module mhb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (en_i && !we_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/multi_ring_history_buffer.sv -----
// top level: ring buffer bank with sample store and pointer/count memory
// stages per input beat: meta read, meta update, store access, then result formatting;
//   one item in flight, so no input beat is taken until the previous result is registered
// a finished result waits in an output register while the next beat is taken
// reset and any size register write start a clearing pass over all
//   MAX_BUFFERS*MAX_LENGTH store words (4096 by default); no input beat is taken during it
module multi_ring_history_buffer
  import mhb_pkg::*;
#(
  parameter int unsigned MAX_BUFFERS = 16,
  parameter int unsigned MAX_LENGTH  = 256,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned BUF_W   = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int unsigned ACT_W   = $clog2(MAX_BUFFERS + 1);
  localparam int unsigned LEN_W   = $clog2(MAX_LENGTH + 1);
  localparam int unsigned PTR_W   = $clog2(MAX_LENGTH);
  localparam int unsigned DEPTH   = MAX_BUFFERS * MAX_LENGTH;
  localparam int unsigned SAW     = $clog2(DEPTH);
  localparam int unsigned META_W  = PTR_W + LEN_W;
  localparam int unsigned CW      = ((LEN_W > 10) ? LEN_W : 10) + 1;
  localparam int unsigned ACT_RST = (MAX_BUFFERS < 16) ? MAX_BUFFERS : 16;
  localparam int unsigned LEN_RST = (MAX_LENGTH < 256) ? MAX_LENGTH : 256;

  state_e state_q, state_d;

  // configuration, kept as effective sizes
  logic [ACT_W-1:0] act_q, act_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [5:0]       csel_q, csel_d;
  logic             cfg_we;
  logic             size_we;

  // clearing pass
  logic [SAW-1:0] clr_q, clr_d;
  logic           clr_last;

  // item and per-item decode results
  in_t              item_q;
  status_e          status_q, status_d;
  logic [SAW-1:0]   base_q, base_d;
  logic [PTR_W-1:0] pos_q, pos_d;
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic             cnt_q, cnt_d;
  logic [LEN_W-1:0] cntv_q;

  // output register
  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  // memory ports
  logic                   meta_en, meta_we;
  logic [BUF_W-1:0]       meta_addr;
  logic [META_W-1:0]      meta_wdata, meta_rdata;
  logic                   st_en, st_we;
  logic [SAW-1:0]         st_addr;
  logic [SAMPLE_BITS-1:0] st_wdata, st_rdata;

  // decode of the stored pointer and count
  logic [PTR_W-1:0]           wp_raw;
  logic [LEN_W-1:0]           fill;
  logic [LEN_W-1:0]           wp_l;
  logic [LEN_W:0]             wp_inc;
  logic [LEN_W-1:0]           wp_new;
  logic [LEN_W-1:0]           fill_new;
  logic                       buf_ok, cnt_ok, off_ok;
  logic [CW-1:0]              steps_c, back_c, hist_c;
  logic [BUF_W+LEN_W-1:0]     prod;
  logic                       op_push, op_hist, op_count, op_write, op_read;
  logic                       in_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cfg_we  = cfg_valid_i;
  assign size_we = cfg_we && ((cfg_index_i == CFG_ACTIVE) || (cfg_index_i == CFG_LENGTH));
  assign clr_last = (clr_q == SAW'(DEPTH - 1));

  // configuration writes with clamping to effective sizes
  always_comb begin
    logic [31:0] tmp;
    act_d  = act_q;
    len_d  = len_q;
    csel_d = csel_q;
    tmp    = '0;
    if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ACTIVE: begin
          tmp = 32'(cfg_data_i[4:0]);
          if (tmp > MAX_BUFFERS) begin
            tmp = MAX_BUFFERS;
          end
          act_d = tmp[ACT_W-1:0];
        end
        CFG_LENGTH: begin
          tmp = 32'(cfg_data_i[8:0]);
          if (tmp == 32'd0) begin
            tmp = 32'd1;
          end
          if (tmp > MAX_LENGTH) begin
            tmp = MAX_LENGTH;
          end
          len_d = tmp[LEN_W-1:0];
        end
        CFG_COUNT_SEL: begin
          csel_d = cfg_data_i[5:0];
        end
        default: begin
        end
      endcase
    end
  end

  // action decode
  always_comb begin
    op_push  = 1'b0;
    op_hist  = 1'b0;
    op_count = 1'b0;
    op_write = 1'b0;
    op_read  = 1'b0;
    case (action_e'(item_q.action))
      ACT_PUSH:  op_push  = 1'b1;
      ACT_HIST:  op_hist  = 1'b1;
      ACT_COUNT: op_count = 1'b1;
      ACT_WRITE: op_write = 1'b1;
      ACT_READ:  op_read  = 1'b1;
      default: begin
      end
    endcase
  end

  // pointer and count arithmetic on the fetched meta word
  always_comb begin
    wp_raw = meta_rdata[META_W-1 -: PTR_W];
    fill   = meta_rdata[LEN_W-1:0];
    wp_l   = LEN_W'(wp_raw);
    if (wp_l >= len_q) begin
      wp_l = '0;
    end
    wp_inc   = (LEN_W + 1)'(wp_l) + 1'b1;
    wp_new   = (wp_inc >= (LEN_W + 1)'(len_q)) ? '0 : wp_inc[LEN_W-1:0];
    fill_new = (fill < len_q) ? fill + 1'b1 : fill;
    buf_ok   = 8'(item_q.buffer_sel) < 8'(act_q);
    cnt_ok   = 8'(csel_q) < 8'(act_q);
    off_ok   = CW'(item_q.elem_offset) < CW'(len_q);
    // history position: clamp depth, step back with wrap
    steps_c  = CW'(item_q.steps_back);
    if (steps_c > CW'(len_q) - 1'b1) begin
      steps_c = CW'(len_q) - 1'b1;
    end
    back_c   = steps_c + 1'b1;
    hist_c   = (CW'(wp_l) >= back_c) ? CW'(wp_l) - back_c
                                     : CW'(wp_l) + CW'(len_q) - back_c;
    prod     = item_q.buffer_sel[BUF_W-1:0] * len_q;
  end

  // per-item decision taken in the meta stage
  always_comb begin
    status_d = STAT_OK;
    wr_d     = 1'b0;
    rd_d     = 1'b0;
    cnt_d    = 1'b0;
    pos_d    = PTR_W'(item_q.elem_offset);
    base_d   = SAW'(prod);
    if (op_count) begin
      if (cnt_ok) begin
        cnt_d = 1'b1;
      end else begin
        status_d = STAT_BAD_BUF;
      end
    end else if (op_push || op_hist || op_write || op_read) begin
      if (!buf_ok) begin
        status_d = STAT_BAD_BUF;
      end else if (op_push) begin
        wr_d  = 1'b1;
        pos_d = PTR_W'(wp_l);
      end else if (op_hist) begin
        rd_d  = 1'b1;
        pos_d = PTR_W'(hist_c);
      end else if (!off_ok) begin
        status_d = STAT_BAD_OFF;
      end else if (op_write) begin
        wr_d = 1'b1;
      end else begin
        rd_d = 1'b1;
      end
    end
  end

  // meta memory port
  always_comb begin
    meta_en    = 1'b0;
    meta_we    = 1'b0;
    meta_addr  = item_q.buffer_sel[BUF_W-1:0];
    meta_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        meta_en   = (32'(clr_q) < MAX_BUFFERS);
        meta_we   = 1'b1;
        meta_addr = clr_q[BUF_W-1:0];
      end
      S_IDLE: begin
        meta_en   = in_acc;
        meta_addr = (in_data_i.action == ACT_COUNT) ? csel_q[BUF_W-1:0]
                                                   : in_data_i.buffer_sel[BUF_W-1:0];
      end
      S_META: begin
        if (buf_ok && op_push) begin
          meta_en    = 1'b1;
          meta_we    = 1'b1;
          meta_wdata = {PTR_W'(wp_new), fill_new};
        end else if (buf_ok && op_write && off_ok && item_q.last_elem) begin
          meta_en    = 1'b1;
          meta_we    = 1'b1;
          meta_wdata = {wp_raw, len_q};
        end
      end
      default: begin
      end
    endcase
  end

  // sample store port
  always_comb begin
    st_en    = 1'b0;
    st_we    = 1'b0;
    st_addr  = base_q + SAW'(pos_q);
    st_wdata = SAMPLE_BITS'(item_q.sample_in);
    case (state_q)
      S_CLEAR: begin
        st_en    = 1'b1;
        st_we    = 1'b1;
        st_addr  = clr_q;
        st_wdata = '0;
      end
      S_ACCESS: begin
        st_en = wr_q || rd_q;
        st_we = wr_q;
      end
      default: begin
      end
    endcase
  end

  // result formatting and output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if ((state_q == S_RESULT) && (!out_valid_q || out_ready_i)) begin
      out_valid_d     = 1'b1;
      out_d.status    = status_q;
      out_d.data_out  = '0;
      if (rd_q) begin
        out_d.data_out = 32'($signed(st_rdata));
      end else if (cnt_q) begin
        out_d.data_out = 32'(cntv_q);
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_META;
        end
      end
      S_META:   state_d = S_ACCESS;
      S_ACCESS: state_d = S_RESULT;
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
    if (size_we) begin
      state_d = S_CLEAR;
      clr_d   = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      act_q       <= ACT_W'(ACT_RST);
      len_q       <= LEN_W'(LEN_RST);
      csel_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      act_q       <= act_d;
      len_q       <= len_d;
      csel_q      <= csel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    if (state_q == S_META) begin
      status_q <= status_d;
      base_q   <= base_d;
      pos_q    <= pos_d;
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      cnt_q    <= cnt_d;
      cntv_q   <= fill;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // write position and fill count per buffer
  mhb_ram #(
    .WIDTH (META_W),
    .DEPTH (MAX_BUFFERS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .en_i    (meta_en),
    .we_i    (meta_we),
    .addr_i  (meta_addr),
    .wdata_i (meta_wdata),
    .rdata_o (meta_rdata)
  );

  // sample store
  mhb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store_ram (
    .clk_i   (clk_i),
    .en_i    (st_en),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata)
  );

endmodule
